### rtl/topq_pkg.sv
// ----------------------------------------------------------------------------
// topq_pkg
// Shared types and constants for the time-ordered priority queue.
// ----------------------------------------------------------------------------
package topq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [47:0] entry_time;
    logic [15:0] record_index;
    logic [31:0] file_handle;
    logic [3:0]  read_position;
  } cmd_t;

  typedef struct packed {
    logic        head_valid;
    logic [47:0] head_time;
    logic [15:0] head_index;
    logic [31:0] head_file;
    logic [4:0]  entry_count;
    logic        read_valid;
    logic [47:0] read_time;
    logic [15:0] read_index;
    logic [31:0] read_file;
    logic        overflow;
  } rsp_t;

  typedef struct packed {
    logic [47:0] entry_time;
    logic [15:0] record_index;
    logic [31:0] file_handle;
  } slot_t;

endpackage

### rtl/topq_slot_ram.sv
// ----------------------------------------------------------------------------
// topq_slot_ram
// Slot storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module topq_slot_ram (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [topq_pkg::IDX_W-1:0] wr_addr,
  input  topq_pkg::slot_t           wr_data,
  input  logic                      rd_en,
  input  logic [topq_pkg::IDX_W-1:0] rd_addr,
  output topq_pkg::slot_t           rd_data
);
  import topq_pkg::*;

  slot_t mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/time_ordered_priority_queue_top.sv
// ----------------------------------------------------------------------------
// time_ordered_priority_queue_top
// Sorted queue of timestamped records held in a circular slot memory.
//
//   channel  dir  handshake             payload
//   cmd      in   cmd_valid/cmd_ready   cmd_t (opcode, record, read position)
//   rsp      out  rsp_valid/rsp_ready   rsp_t (head, count, read data, flag)
//
// Remove, clear and an insert into an empty or full queue go straight to a read
// of the head slot; a read first fetches its slot, and any other insert first
// moves back each later record, as one compare unit walks the slot memory from
// the tail, one slot a cycle through its single read port.
// Reset empties the queue at once; no clearing pass.
// A result waits in the output register while the next command is taken;
// a command finishes only when that register is free.
// ----------------------------------------------------------------------------
module time_ordered_priority_queue_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  topq_pkg::cmd_t cmd,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output topq_pkg::rsp_t rsp
);
  import topq_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SHIFT  = 3'd1;
  localparam logic [2:0] ST_PLACE  = 3'd2;
  localparam logic [2:0] ST_RDWAIT = 3'd3;
  localparam logic [2:0] ST_HEAD   = 3'd4;
  localparam logic [2:0] ST_HWAIT  = 3'd5;

  logic [2:0]       state, state_next;
  logic [IDX_W-1:0] base, base_next;
  logic [CNT_W-1:0] count, count_next;
  logic [IDX_W-1:0] k, k_next;
  slot_t            new_slot, new_slot_next;
  slot_t            rd_slot, rd_slot_next;
  logic             rd_hit, rd_hit_next;
  logic             ovf, ovf_next;
  rsp_t             rsp_next;
  logic             rsp_valid_next;

  logic             wr_en, rd_en;
  logic [IDX_W-1:0] wr_log, rd_log;
  slot_t            wr_data, rd_data;
  slot_t            cmd_slot;

  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] b,
                                            input logic [IDX_W-1:0] l);
    logic [IDX_W:0] s;
    s = {1'b0, b} + {1'b0, l};
    if (s >= (IDX_W+1)'(QUEUE_DEPTH)) begin
      s = s - (IDX_W+1)'(QUEUE_DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  topq_slot_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (phys(base, wr_log)),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (phys(base, rd_log)),
    .rd_data (rd_data)
  );

  assign cmd_ready = (state == ST_IDLE);
  assign cmd_slot  = '{entry_time: cmd.entry_time, record_index: cmd.record_index,
                       file_handle: cmd.file_handle};

  always_comb begin
    state_next     = state;
    base_next      = base;
    count_next     = count;
    k_next         = k;
    new_slot_next  = new_slot;
    rd_slot_next   = rd_slot;
    rd_hit_next    = rd_hit;
    ovf_next       = ovf;
    rsp_next       = rsp;
    rsp_valid_next = rsp_valid && !rsp_ready;
    wr_en          = 1'b0;
    wr_log         = '0;
    wr_data        = new_slot;
    rd_en          = 1'b0;
    rd_log         = '0;

    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          new_slot_next = cmd_slot;
          ovf_next      = 1'b0;
          rd_hit_next   = 1'b0;
          rd_slot_next  = '0;
          state_next    = ST_HEAD;
          unique case (cmd.opcode)
            OP_INSERT: begin
              if (count == CNT_W'(QUEUE_DEPTH)) begin
                ovf_next = 1'b1;
              end else if (count == '0) begin
                wr_en      = 1'b1;
                wr_data    = cmd_slot;
                count_next = count + 1'b1;
              end else begin
                k_next     = IDX_W'(count - 1'b1);
                rd_en      = 1'b1;
                rd_log     = IDX_W'(count - 1'b1);
                state_next = ST_SHIFT;
              end
            end
            OP_REMOVE: begin
              if (count != '0) begin
                base_next  = phys(base, IDX_W'(1));
                count_next = count - 1'b1;
              end
            end
            OP_CLEAR: begin
              count_next = '0;
            end
            OP_READ: begin
              if (32'(cmd.read_position) < 32'(count)) begin
                rd_en      = 1'b1;
                rd_log     = IDX_W'(cmd.read_position);
                state_next = ST_RDWAIT;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SHIFT: begin
        wr_en = 1'b1;
        wr_log = k + 1'b1;
        if (rd_data.entry_time > new_slot.entry_time) begin
          wr_data = rd_data;
          if (k == '0) begin
            state_next = ST_PLACE;
          end else begin
            rd_en  = 1'b1;
            rd_log = k - 1'b1;
            k_next = k - 1'b1;
          end
        end else begin
          wr_data    = new_slot;
          count_next = count + 1'b1;
          state_next = ST_HEAD;
        end
      end
      ST_PLACE: begin
        wr_en      = 1'b1;
        wr_data    = new_slot;
        count_next = count + 1'b1;
        state_next = ST_HEAD;
      end
      ST_RDWAIT: begin
        rd_hit_next  = 1'b1;
        rd_slot_next = rd_data;
        state_next   = ST_HEAD;
      end
      ST_HEAD: begin
        rd_en      = 1'b1;
        state_next = ST_HWAIT;
      end
      ST_HWAIT: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_next.head_valid  = (count != '0);
          rsp_next.head_time   = (count != '0) ? rd_data.entry_time : '0;
          rsp_next.head_index  = (count != '0) ? rd_data.record_index : '0;
          rsp_next.head_file   = (count != '0) ? rd_data.file_handle : '0;
          rsp_next.entry_count = 5'(count);
          rsp_next.read_valid  = rd_hit;
          rsp_next.read_time   = rd_slot.entry_time;
          rsp_next.read_index  = rd_slot.record_index;
          rsp_next.read_file   = rd_slot.file_handle;
          rsp_next.overflow    = ovf;
          rsp_valid_next       = 1'b1;
          state_next           = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      base      <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      base      <= base_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    k        <= k_next;
    new_slot <= new_slot_next;
    rd_slot  <= rd_slot_next;
    rd_hit   <= rd_hit_next;
    ovf      <= ovf_next;
    rsp      <= rsp_next;
  end

endmodule

### rtl/topq_checker.sv
// ----------------------------------------------------------------------------
// topq_checker
// Port-level checks for the time-ordered priority queue.
// ----------------------------------------------------------------------------
module topq_checker (
  input logic           clk,
  input logic           rst,
  input logic           cmd_valid,
  input logic           cmd_ready,
  input topq_pkg::cmd_t cmd,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input topq_pkg::rsp_t rsp
);
  import topq_pkg::*;

  // one command in flight at a time
  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command taken while previous one in flight");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.head_valid == (rsp.entry_count != 5'd0))
    else $error("head valid disagrees with count");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.overflow |-> rsp.entry_count == 5'(QUEUE_DEPTH))
    else $error("overflow reported on a queue that is not full");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.head_valid |-> rsp.head_time == '0 && !rsp.read_valid)
    else $error("empty queue reports a record");

endmodule

bind time_ordered_priority_queue_top topq_checker u_topq_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_ready (cmd_ready),
  .cmd       (cmd),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
